// ----- hw/rtl/prhp_pkg.sv -----
// ----------------------------------------------------------------------------
// prhp_pkg
// types and constants shared by the proxy request header parser
// ----------------------------------------------------------------------------
`default_nettype none

package prhp_pkg;

  // parse phase, also used as the byte role tag
  typedef enum logic [3:0] {
    PH_PASS  = 4'd0,
    PH_CR1   = 4'd1,
    PH_LF1   = 4'd2,
    PH_CMD   = 4'd3,
    PH_ATYP  = 4'd4,
    PH_ADDR  = 4'd5,
    PH_NLEN  = 4'd6,
    PH_PORTH = 4'd7,
    PH_PORTL = 4'd8,
    PH_CR2   = 4'd9,
    PH_LF2   = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_DONE  = 3'd1,
    ST_CRLF  = 3'd2,
    ST_ATYP  = 3'd3,
    ST_NLEN  = 3'd4,
    ST_TRUNC = 3'd5
  } status_t;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] ATYP_IPV4  = 8'd1;
  localparam logic [7:0] ATYP_NAME  = 8'd3;
  localparam logic [7:0] ATYP_IPV6  = 8'd4;
  localparam logic [7:0] IPV4_BYTES = 8'd4;
  localparam logic [7:0] IPV6_BYTES = 8'd16;
  localparam logic [8:0] LEN_MAX    = 9'd511;

  // one parsed result, as it travels from the parser core to the output stage
  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  field_offset;
    status_t     status;
    logic [8:0]  header_length;
    logic [7:0]  command;
    logic [7:0]  address_type;
    logic [15:0] dest_port;
  } result_t;

endpackage : prhp_pkg

`default_nettype wire

// ----- hw/rtl/prhp_core.sv -----
// ----------------------------------------------------------------------------
// prhp_core
// parse state registers and the per-byte next-state and tagging logic
// ----------------------------------------------------------------------------
`default_nettype none

module prhp_core
  import prhp_pkg::*;
#(
  parameter int PASSWORD_BYTES = 56
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  fpos_r, fpos_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [8:0]  count_r, count_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  atyp_r, atyp_nxt;
  logic [15:0] port_r, port_nxt;

  logic [8:0]  len;
  logic [8:0]  pass_inc;
  logic [7:0]  addr_inc;
  logic [7:0]  offset;
  logic [3:0]  role;
  status_t     st;
  status_t     st_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PASS;
      fpos_r  <= '0;
      nlen_r  <= '0;
      count_r <= '0;
      cmd_r   <= '0;
      atyp_r  <= '0;
      port_r  <= '0;
    end else if (step_en) begin
      if (st_final != ST_BUSY) begin
        phase_r <= PH_PASS;
        fpos_r  <= '0;
        nlen_r  <= '0;
        count_r <= '0;
        cmd_r   <= '0;
        atyp_r  <= '0;
        port_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        fpos_r  <= fpos_nxt;
        nlen_r  <= nlen_nxt;
        count_r <= count_nxt;
        cmd_r   <= cmd_nxt;
        atyp_r  <= atyp_nxt;
        port_r  <= port_nxt;
      end
    end
  end

  always_comb begin
    len       = (count_r == LEN_MAX) ? LEN_MAX : count_r + 9'd1;
    pass_inc  = {1'b0, fpos_r} + 9'd1;
    addr_inc  = fpos_r + 8'd1;
    phase_nxt = phase_r;
    fpos_nxt  = fpos_r;
    nlen_nxt  = nlen_r;
    count_nxt = len;
    cmd_nxt   = cmd_r;
    atyp_nxt  = atyp_r;
    port_nxt  = port_r;
    offset    = '0;
    st        = ST_BUSY;
    role      = phase_r;

    unique case (phase_r) inside
      PH_CR1, PH_CR2: begin
        if (data_byte != CHAR_CR) begin
          st = ST_CRLF;
        end else if (phase_r == PH_CR1) begin
          phase_nxt = PH_LF1;
        end else begin
          phase_nxt = PH_LF2;
        end
      end
      PH_LF1, PH_LF2: begin
        offset = 8'd1;
        if (data_byte != CHAR_LF) begin
          st = ST_CRLF;
        end else if (phase_r == PH_LF2) begin
          st = ST_DONE;
        end else begin
          phase_nxt = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_nxt   = data_byte;
        phase_nxt = PH_ATYP;
      end
      PH_ATYP: begin
        atyp_nxt = data_byte;
        fpos_nxt = '0;
        if (data_byte == ATYP_IPV4) begin
          nlen_nxt  = IPV4_BYTES;
          phase_nxt = PH_ADDR;
        end else if (data_byte == ATYP_IPV6) begin
          nlen_nxt  = IPV6_BYTES;
          phase_nxt = PH_ADDR;
        end else if (data_byte == ATYP_NAME) begin
          phase_nxt = PH_NLEN;
        end else begin
          st = ST_ATYP;
        end
      end
      PH_NLEN: begin
        if (data_byte == 8'd0) begin
          st = ST_NLEN;
        end else begin
          nlen_nxt  = data_byte;
          fpos_nxt  = '0;
          phase_nxt = PH_ADDR;
        end
      end
      PH_ADDR: begin
        offset = fpos_r;
        if (addr_inc >= nlen_r) begin
          fpos_nxt  = '0;
          phase_nxt = PH_PORTH;
        end else begin
          fpos_nxt = addr_inc;
        end
      end
      PH_PORTH: begin
        port_nxt  = {data_byte, 8'd0};
        phase_nxt = PH_PORTL;
      end
      PH_PORTL: begin
        offset    = 8'd1;
        port_nxt  = {port_r[15:8], data_byte};
        phase_nxt = PH_CR2;
      end
      default: begin
        // password bytes; unused phase codes fall here as well
        role   = PH_PASS;
        offset = fpos_r;
        if (pass_inc >= 9'(PASSWORD_BYTES)) begin
          fpos_nxt  = '0;
          phase_nxt = PH_CR1;
        end else begin
          fpos_nxt  = pass_inc[7:0];
          phase_nxt = PH_PASS;
        end
      end
    endcase

    st_final = (st == ST_BUSY && last_byte) ? ST_TRUNC : st;

    res.byte_role     = role;
    res.field_offset  = offset;
    res.status        = st_final;
    res.header_length = len;
    res.command       = cmd_nxt;
    res.address_type  = atyp_nxt;
    res.dest_port     = port_nxt;
  end

endmodule : prhp_core

`default_nettype wire

// ----- hw/rtl/prhp_out_reg.sv -----
// ----------------------------------------------------------------------------
// prhp_out_reg
// result register with valid flag between the parser and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module prhp_out_reg
  import prhp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    take,
  output logic         valid,
  output result_t      res_out
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule : prhp_out_reg

`default_nettype wire

// ----- hw/rtl/proxy_request_header_parser.sv -----
// ----------------------------------------------------------------------------
// proxy_request_header_parser
// byte-at-a-time parser for a password + socks5 address request header
// ----------------------------------------------------------------------------
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   in_     | sink      | tdata = header byte, tlast = end of buffer
//   out_    | source    | tdata = offset/status/length/cmd/atyp/port,
//           |           | tuser = byte role
//
// - one transaction per cycle sustained while the result side keeps up; each
//   byte's result shows up in the cycle after acceptance, set by the single result register
// - parse state updates in the same cycle the byte is taken, so the next
//   byte can follow immediately
// - in_tready stays high while the result register is empty or being drained,
//   so a stall on the result side holds at most one result
// - synchronous active-low reset returns the parser to the first password byte
// - after done or any error (including truncation) the next byte begins a
//   new header
//
`default_nettype none

module proxy_request_header_parser
  import prhp_pkg::*;
#(
  parameter int PASSWORD_BYTES = 56  // password length, 1 to 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] field_offset, [10:8] status,
                                       // [19:11] header_length, [27:20] command,
                                       // [35:28] address_type, [51:36] dest_port,
                                       // [55:52] zero
  output logic [3:0]       out_tuser   // [3:0] byte_role
);

  logic    in_fire;
  result_t core_res;
  result_t out_res;

  // accept whenever the result slot is free or is emptied this cycle
  assign in_tready = rst_n && (!out_tvalid || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // parse state and per-byte tagging
  prhp_core #(
    .PASSWORD_BYTES (PASSWORD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_fire),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res       (core_res)
  );

  // registered result toward the consumer
  prhp_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_fire),
    .res_in  (core_res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (out_res)
  );

  // pack result fields, lowest field first
  assign out_tdata = {4'd0,
                      out_res.dest_port,
                      out_res.address_type,
                      out_res.command,
                      out_res.header_length,
                      3'(out_res.status),
                      out_res.field_offset};
  assign out_tuser = out_res.byte_role;

endmodule : proxy_request_header_parser

`default_nettype wire

// ----- hw/rtl/prhp_checker.sv -----
// ----------------------------------------------------------------------------
// prhp_checker
// port-level checks for the proxy request header parser
// ----------------------------------------------------------------------------
`default_nettype none

module prhp_checker
  import prhp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [3:0]  out_tuser
);

  logic [2:0] st;
  assign st = out_tdata[10:8];

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // every accepted byte produces a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte produced no result");

  // done only on the closing line feed
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_DONE |-> out_tuser == PH_LF2)
    else $error("done status on a byte other than the closing lf");

  // crlf error only on a cr or lf byte
  a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_CRLF |->
      (out_tuser == PH_CR1 || out_tuser == PH_LF1 ||
       out_tuser == PH_CR2 || out_tuser == PH_LF2))
    else $error("crlf error outside a cr or lf byte");

  // address type error only on the type byte
  a_atyp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_ATYP |-> out_tuser == PH_ATYP)
    else $error("address type error on the wrong byte");

endmodule : prhp_checker

bind proxy_request_header_parser prhp_checker u_prhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/sv/prhp_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// prhp_scoreboard_pkg
// header parse predictor and result checker for the request header parser
// ----------------------------------------------------------------------------
package prhp_scoreboard_pkg;

  import prhp_pkg::*;

  class header_scoreboard;

    int unsigned pw_bytes;

    // predicted parser state
    phase_t      phase;
    logic [7:0]  field_pos;
    logic [7:0]  addr_len;
    logic [8:0]  consumed;
    logic [7:0]  cmd_seen;
    logic [7:0]  atyp_seen;
    logic [15:0] port_acc;

    result_t     expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned endings[6];

    function new(int unsigned pw);
      pw_bytes = pw;
      errors   = 0;
      checked  = 0;
      foreach (endings[i]) endings[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_PASS;
      field_pos = '0;
      addr_len  = '0;
      consumed  = '0;
      cmd_seen  = '0;
      atyp_seen = '0;
      port_acc  = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // parse one accepted byte and queue the result it must produce
    function void note_input(logic [7:0] b, logic last);
      phase_t     cur;
      logic [7:0] offset;
      status_t    st;
      result_t    r;
      cur    = phase;
      offset = '0;
      st     = ST_BUSY;
      if (consumed != LEN_MAX) consumed = consumed + 9'd1;
      case (cur)
        PH_PASS: begin
          offset    = field_pos;
          field_pos = field_pos + 8'd1;
          if (field_pos >= pw_bytes) begin
            field_pos = '0;
            phase     = PH_CR1;
          end
        end
        PH_CR1, PH_CR2: begin
          if (b != CHAR_CR) st = ST_CRLF;
          else phase = (cur == PH_CR1) ? PH_LF1 : PH_LF2;
        end
        PH_LF1, PH_LF2: begin
          offset = 8'd1;
          if (b != CHAR_LF) st = ST_CRLF;
          else if (cur == PH_LF2) st = ST_DONE;
          else phase = PH_CMD;
        end
        PH_CMD: begin
          cmd_seen = b;
          phase    = PH_ATYP;
        end
        PH_ATYP: begin
          atyp_seen = b;
          field_pos = '0;
          if (b == ATYP_IPV4) begin
            addr_len = IPV4_BYTES;
            phase    = PH_ADDR;
          end else if (b == ATYP_IPV6) begin
            addr_len = IPV6_BYTES;
            phase    = PH_ADDR;
          end else if (b == ATYP_NAME) begin
            phase = PH_NLEN;
          end else begin
            st = ST_ATYP;
          end
        end
        PH_NLEN: begin
          if (b == 8'd0) begin
            st = ST_NLEN;
          end else begin
            addr_len  = b;
            field_pos = '0;
            phase     = PH_ADDR;
          end
        end
        PH_ADDR: begin
          offset    = field_pos;
          field_pos = field_pos + 8'd1;
          if (field_pos >= addr_len) begin
            field_pos = '0;
            phase     = PH_PORTH;
          end
        end
        PH_PORTH: begin
          port_acc = {b, 8'h00};
          phase    = PH_PORTL;
        end
        default: begin
          offset   = 8'd1;
          port_acc = port_acc | {8'h00, b};
          phase    = PH_CR2;
        end
      endcase
      if (st == ST_BUSY && last) st = ST_TRUNC;

      r.byte_role     = cur;
      r.field_offset  = offset;
      r.status        = st;
      r.header_length = consumed;
      r.command       = cmd_seen;
      r.address_type  = atyp_seen;
      r.dest_port     = port_acc;
      expected_q.push_back(r);

      if (st != ST_BUSY) begin
        endings[st]++;
        clear_state();
      end
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] tdata, logic [3:0] tuser);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no byte outstanding: tdata=%h tuser=%h", tdata, tuser);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("byte_role", want.byte_role, tuser);
      compare("field_offset", want.field_offset, tdata[7:0]);
      compare("status", want.status, tdata[10:8]);
      compare("header_length", want.header_length, tdata[19:11]);
      compare("command", want.command, tdata[27:20]);
      compare("address_type", want.address_type, tdata[35:28]);
      compare("dest_port", want.dest_port, tdata[51:36]);
      compare("tdata padding", 16'd0, tdata[55:52]);
    endfunction

  endclass

endpackage : prhp_scoreboard_pkg

// ----- tb/sv/proxy_request_header_parser_tb.sv -----
// ----------------------------------------------------------------------------
// proxy_request_header_parser_tb
// drives password + socks5 address request headers through the parser and
// checks every per-byte result against a cycle-free header predictor
// ----------------------------------------------------------------------------
module proxy_request_header_parser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import prhp_pkg::*;
  import prhp_scoreboard_pkg::*;

  localparam int PW_BYTES    = 56;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_BYTES  = 170;   // per pacing phase

  // which part of a header gets corrupted
  typedef enum int {
    FAULT_NONE = 0,
    FAULT_CR1  = 1,
    FAULT_LF1  = 2,
    FAULT_ATYP = 3,
    FAULT_NLEN = 4,
    FAULT_CR2  = 5,
    FAULT_LF2  = 6
  } fault_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [3:0]  out_tuser;

  header_scoreboard sb;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycles         = 0;

  proxy_request_header_parser #(
    .PASSWORD_BYTES(PW_BYTES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result monitor: every accepted result transaction is checked in order
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // one byte transaction; called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata  = $urandom;
      in_tlast  = $urandom;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // builds a well formed header, then optionally corrupts one byte (cutting
  // the rest) and/or ends the buffer early at trunc_at
  task automatic send_header(fault_t fault, logic [7:0] atyp, int unsigned nlen,
                             logic [7:0] cmd, logic [15:0] port, logic [7:0] bad,
                             int trunc_at, bit last_on_end);
    logic [7:0]  q[$];
    int          cut;
    bit          mark_last;
    int unsigned alen;
    alen = (atyp == ATYP_IPV4) ? 4 : (atyp == ATYP_IPV6) ? 16 : nlen;
    for (int i = 0; i < PW_BYTES; i++) q.push_back($urandom);
    q.push_back(CHAR_CR);
    q.push_back(CHAR_LF);
    q.push_back(cmd);
    q.push_back(atyp);
    if (atyp == ATYP_NAME) q.push_back(nlen[7:0]);
    for (int i = 0; i < alen; i++) q.push_back($urandom);
    q.push_back(port[15:8]);
    q.push_back(port[7:0]);
    q.push_back(CHAR_CR);
    q.push_back(CHAR_LF);

    cut = -1;
    case (fault)
      FAULT_CR1:  cut = PW_BYTES;
      FAULT_LF1:  cut = PW_BYTES + 1;
      FAULT_ATYP: cut = PW_BYTES + 3;
      FAULT_NLEN: cut = PW_BYTES + 4;
      FAULT_CR2:  cut = q.size() - 2;
      FAULT_LF2:  cut = q.size() - 1;
      default: ;
    endcase
    if (cut >= 0) begin
      q[cut] = bad;
      q = q[0:cut];
    end
    mark_last = last_on_end;
    // end of buffer before the header is complete
    if (trunc_at >= 0 && trunc_at < q.size() - 1) begin
      q = q[0:trunc_at];
      mark_last = 1'b1;
    end
    for (int i = 0; i < q.size(); i++) send_byte(q[i], mark_last && (i == q.size() - 1));
  endtask

  // a byte that breaks the chosen field
  function automatic logic [7:0] pick_bad(fault_t fault);
    logic [7:0] v;
    v = 8'h00;
    case (fault)
      FAULT_CR1, FAULT_CR2: do v = $urandom; while (v == CHAR_CR);
      FAULT_LF1, FAULT_LF2: do v = $urandom; while (v == CHAR_LF);
      FAULT_ATYP: do v = $urandom; while (v == ATYP_IPV4 || v == ATYP_IPV6 || v == ATYP_NAME);
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // mostly well formed headers with random content, some corrupted or cut
  // short, plus short bursts of junk that end on a buffer boundary
  task automatic run_random(int unsigned n);
    int unsigned target;
    int unsigned r;
    int unsigned nlen;
    int unsigned burst;
    logic [7:0]  atyp;
    fault_t      fault;
    int          trunc_at;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) begin
        burst = $urandom_range(1, 8);
        for (int i = 0; i < burst; i++) send_byte($urandom, i == burst - 1);
      end else begin
        r    = $urandom_range(99);
        atyp = (r < 40) ? ATYP_IPV4 : (r < 60) ? ATYP_IPV6 : ATYP_NAME;
        r    = $urandom_range(99);
        nlen = (r < 90) ? $urandom_range(1, 24) : (r < 95) ? 255 : $urandom_range(25, 254);
        fault = ($urandom_range(99) < 70) ? FAULT_NONE : fault_t'($urandom_range(1, 6));
        if (fault == FAULT_NLEN) atyp = ATYP_NAME;
        trunc_at = ($urandom_range(99) < 15) ? int'($urandom_range(0, 90)) : -1;
        send_header(fault, atyp, nlen, $urandom, $urandom, pick_bad(fault), trunc_at,
                    $urandom_range(1));
      end
    end
  endtask

  int unsigned src_pct[4]  = '{0, 75, 0, 10};
  int unsigned sink_pct[4] = '{0, 0, 75, 10};

  initial begin
    sb = new(PW_BYTES);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_pct[p];
      sink_stall_pct = sink_pct[p];
      if (p == 0) begin
        // good headers: each address type, field extremes
        send_header(FAULT_NONE, ATYP_IPV4, 0,   8'h00, 16'h0000, 8'h00, -1, 1'b1);
        send_header(FAULT_NONE, ATYP_IPV6, 0,   8'hFF, 16'hFFFF, 8'h00, -1, 1'b0);
        send_header(FAULT_NONE, ATYP_NAME, 1,   8'h01, 16'h1234, 8'h00, -1, 1'b0);
        send_header(FAULT_NONE, ATYP_NAME, 255, 8'h03, 16'h8001, 8'h00, -1, 1'b1);
        // broken delimiters
        send_header(FAULT_CR1, ATYP_IPV4, 0, 8'h01, 16'h0050, CHAR_LF, -1, 1'b0);
        send_header(FAULT_LF1, ATYP_IPV4, 0, 8'h01, 16'h0050, CHAR_CR, -1, 1'b0);
        send_header(FAULT_CR2, ATYP_IPV6, 0, 8'h01, 16'h0050, 8'h00,   -1, 1'b0);
        send_header(FAULT_LF2, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'hFF,   -1, 1'b0);
        // unknown address types, empty domain name
        send_header(FAULT_ATYP, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'h00, -1, 1'b0);
        send_header(FAULT_ATYP, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'h02, -1, 1'b0);
        send_header(FAULT_ATYP, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'hFF, -1, 1'b0);
        send_header(FAULT_NLEN, ATYP_NAME, 5, 8'h01, 16'h0050, 8'h00, -1, 1'b0);
        // buffer ends on the very first byte, and inside the address
        send_header(FAULT_NONE, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'h00, 0, 1'b0);
        send_header(FAULT_NONE, ATYP_IPV6, 0, 8'h01, 16'h0050, 8'h00, PW_BYTES + 6, 1'b0);
        // error and end of buffer on the same byte: the error wins
        send_header(FAULT_CR1, ATYP_IPV4, 0, 8'h01, 16'h0050, 8'h00, -1, 1'b1);
        // pressure: nothing new until every result has drained
        wait_drained();
      end
      run_random(RAND_BYTES);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d header bytes over four pacing phases, %0d results checked",
             bytes_sent, sb.checked);
    $display("headers ended: %0d done, %0d crlf, %0d bad type, %0d empty name, %0d cut short",
             sb.endings[ST_DONE], sb.endings[ST_CRLF], sb.endings[ST_ATYP],
             sb.endings[ST_NLEN], sb.endings[ST_TRUNC]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : proxy_request_header_parser_tb

// ----- sim.f -----
hw/rtl/prhp_pkg.sv
hw/rtl/prhp_core.sv
hw/rtl/prhp_out_reg.sv
hw/rtl/proxy_request_header_parser.sv
hw/rtl/prhp_checker.sv
tb/sv/prhp_scoreboard_pkg.sv
tb/sv/proxy_request_header_parser_tb.sv
